FILE: design/htf_pkg.sv
// shared constants, types and tables of the homogeneous transform engine
// no dependencies; imported by the cordic, mac and top level files
`default_nettype none
package htf_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;

	// cordic works at 30 fraction bits
	localparam int CF           = 30;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < CF) ? CORDIC_STEPS : CF;
	localparam int ITER_W       = $clog2(CF);
	localparam int CW           = 34;

	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);
	localparam logic signed [31:0] RAD_PER_SIXTEENTH = 32'sd1199381129;
	localparam logic signed [15:0] FULL_TURN    = 16'sd5760;
	localparam logic signed [15:0] HALF_TURN    = 16'sd2880;
	localparam logic signed [15:0] QUARTER_TURN = 16'sd1440;

	// action codes
	localparam logic [2:0] ACT_IDENT = 3'd0;
	localparam logic [2:0] ACT_LOAD  = 3'd1;
	localparam logic [2:0] ACT_ROTX  = 3'd2;
	localparam logic [2:0] ACT_ROTY  = 3'd3;
	localparam logic [2:0] ACT_ROTZ  = 3'd4;
	localparam logic [2:0] ACT_TRANS = 3'd5;
	localparam logic [2:0] ACT_POINT = 3'd6;

	localparam int S_DATA_W = 184;
	localparam int S_USER_W = 4;
	localparam int M_DATA_W = 128;

	typedef struct packed {
		logic mul_en;
		logic acc_clr;
		logic acc_en;
	} mac_ctrl_t;

	function automatic logic signed [31:0] atan_q30(input logic [ITER_W-1:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'sd843314857;
			5'd1:  r = 32'sd497837829;
			5'd2:  r = 32'sd263043837;
			5'd3:  r = 32'sd133525159;
			5'd4:  r = 32'sd67021687;
			5'd5:  r = 32'sd33543516;
			5'd6:  r = 32'sd16775851;
			5'd7:  r = 32'sd8388437;
			5'd8:  r = 32'sd4194283;
			5'd9:  r = 32'sd2097149;
			5'd10: r = 32'sd1048576;
			5'd11: r = 32'sd524288;
			5'd12: r = 32'sd262144;
			5'd13: r = 32'sd131072;
			5'd14: r = 32'sd65536;
			5'd15: r = 32'sd32768;
			5'd16: r = 32'sd16384;
			5'd17: r = 32'sd8192;
			5'd18: r = 32'sd4096;
			5'd19: r = 32'sd2048;
			5'd20: r = 32'sd1024;
			5'd21: r = 32'sd512;
			5'd22: r = 32'sd256;
			5'd23: r = 32'sd128;
			5'd24: r = 32'sd64;
			5'd25: r = 32'sd32;
			5'd26: r = 32'sd16;
			5'd27: r = 32'sd8;
			5'd28: r = 32'sd4;
			5'd29: r = 32'sd2;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/htf_cordic.sv
// iterative cordic: angle reduction, fold, scaling and one rotation step a cycle
// depends on htf_pkg
`default_nettype none
module htf_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] angle,
	output logic                    done,
	output logic signed [31:0]      sn,
	output logic signed [31:0]      cs
);
	import htf_pkg::*;

	localparam int SH = CF - FRAC_BITS;
	localparam logic signed [CW:0] RND = (CW+1)'((64'sd1 <<< SH) >>> 1);
	localparam logic signed [CW:0] ONE_W = (CW+1)'(ONE);

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_RED  = 3'd1;
	localparam logic [2:0] C_MUL  = 3'd2;
	localparam logic [2:0] C_SCL  = 3'd3;
	localparam logic [2:0] C_ITER = 3'd4;
	localparam logic [2:0] C_OUT  = 3'd5;

	logic [2:0]              st_q;
	logic signed [15:0]      a_q;
	logic                    neg_q;
	logic signed [47:0]      prod_q;
	logic signed [CW-1:0]    x_q, y_q, z_q;
	logic [ITER_W-1:0]       i_q;
	logic signed [CW-1:0]    dx, dy, xf, yf;
	logic signed [47:0]      zr;
	logic signed [CW:0]      sr, cr;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign xf = neg_q ? -x_q : x_q;
	assign yf = neg_q ? -y_q : y_q;
	assign zr = (prod_q + 48'sd512) >>> 10;
	assign sr = ($signed({yf[CW-1], yf}) + RND) >>> SH;
	assign cr = ($signed({xf[CW-1], xf}) + RND) >>> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				C_IDLE: begin
					if (start) begin
						a_q  <= angle;
						st_q <= C_RED;
					end
				end
				C_RED: begin
					// bring into (-half, half], then fold into the quarter range
					if (a_q > HALF_TURN) begin
						a_q <= a_q - FULL_TURN;
					end else if (a_q <= -HALF_TURN) begin
						a_q <= a_q + FULL_TURN;
					end else begin
						if (a_q > QUARTER_TURN) begin
							a_q   <= a_q - HALF_TURN;
							neg_q <= 1'b1;
						end else if (a_q < -QUARTER_TURN) begin
							a_q   <= a_q + HALF_TURN;
							neg_q <= 1'b1;
						end else begin
							neg_q <= 1'b0;
						end
						st_q <= C_MUL;
					end
				end
				C_MUL: begin
					prod_q <= 48'(a_q) * 48'(RAD_PER_SIXTEENTH);
					st_q   <= C_SCL;
				end
				C_SCL: begin
					z_q  <= zr[CW-1:0];
					x_q  <= GAIN_INV;
					y_q  <= '0;
					i_q  <= '0;
					st_q <= C_ITER;
				end
				C_ITER: begin
					if (!z_q[CW-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - CW'(atan_q30(i_q));
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + CW'(atan_q30(i_q));
					end
					if (i_q == ITER_W'(CORDIC_ITERS - 1)) begin
						st_q <= C_OUT;
					end
					i_q <= i_q + 1'b1;
				end
				C_OUT: begin
					sn   <= (sr > ONE_W) ? ONE : (sr < -ONE_W) ? -ONE : sr[31:0];
					cs   <= (cr > ONE_W) ? ONE : (cr < -ONE_W) ? -ONE : cr[31:0];
					done <= 1'b1;
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/htf_mac.sv
// shared multiply-accumulate unit with round-half-up and 32-bit saturation
// depends on htf_pkg
`default_nettype none
module htf_mac (
	input  wire logic               clk,
	input  wire htf_pkg::mac_ctrl_t ctrl,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [31:0]      result,
	output logic                    ovf
);
	import htf_pkg::*;

	localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

	logic signed [63:0] prod_s1;
	logic signed [65:0] acc_q;
	logic signed [66:0] sh;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= 64'(a) * 64'(b);
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + {{2{prod_s1[63]}}, prod_s1};
		end
	end

	assign sh = ($signed({acc_q[65], acc_q}) + HALF) >>> FRAC_BITS;
	always_comb begin
		ovf = 1'b0;
		result = sh[31:0];
		if (sh > 67'sd2147483647) begin
			ovf = 1'b1;
			result = 32'sh7fffffff;
		end else if (sh < -67'sd2147483648) begin
			ovf = 1'b1;
			result = 32'sh80000000;
		end
	end

endmodule
`default_nettype wire

FILE: design/homogeneous_transform_engine_unit.sv
// top level of the homogeneous 4x4 transform engine: sequencer, matrix banks, output stage
// depends on htf_pkg, htf_cordic and htf_mac
//
// usage:
//  - slave channel: one beat is one action; tuser = action, order; tdata = row, col,
//    value, angle, x, y, z, w. the block keeps a 4x4 q16.16 matrix
//  - identity and load finish in the accept cycle; action 7 does nothing
//  - rotations run the cordic (angle reduction, one full turn removed per step, then
//    fold, scaling and the rotation steps) and then compose like a translation
//  - a composition uses one shared multiplier, the single multiply-accumulate unit,
//    for the 16 elements, one element after another
//  - transform point runs on the same unit, then the result beat goes
//    to the master channel: tdata = out_x, out_y, out_z, out_w; tuser = saturated
//  - tready is low while an action is at work
//  - a result waiting on a stalled receiver does not block new beats; only the next
//    point transform waits to hand over its result
//  - reset clears the matrix to zeros with a one in the last diagonal element and
//    clears the saturation flag
`default_nettype none
module homogeneous_transform_engine_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// row, col, value, angle, x, y, z, w, zero fill
	input  wire logic [htf_pkg::S_DATA_W-1:0] s_tdata,
	// action, order
	input  wire logic [htf_pkg::S_USER_W-1:0] s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// out_x, out_y, out_z, out_w
	output logic [htf_pkg::M_DATA_W-1:0]      m_tdata,
	// saturated
	output logic                              m_tuser
);
	import htf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CORD = 2'd1;
	localparam logic [1:0] ST_MAC  = 2'd2;
	localparam logic [1:0] ST_PUT  = 2'd3;

	logic [1:0]              state_q;
	logic signed [31:0]      bank_q [2][16];   // two banks, compose writes the idle one
	logic                    act_q;
	logic                    ov_q;
	logic [2:0]              action_q;
	logic                    order_q;
	logic signed [31:0]      vec_q [4];        // x, y, z, w
	logic signed [31:0]      res_q [4];
	logic [1:0]              i_q, j_q;
	logic [2:0]              t_q;

	logic                    acc_beat;
	logic [2:0]              in_action;
	logic [3:0]              in_idx;
	logic                    cord_start, cord_done;
	logic signed [31:0]      sn, cs;
	mac_ctrl_t               mctl;
	logic signed [31:0]      op_a, op_b, mac_res;
	logic                    mac_ovf;
	logic [1:0]              k;
	logic                    is_point;

	assign s_tready  = (state_q == ST_IDLE);
	assign acc_beat  = s_tvalid && s_tready;
	assign in_action = s_tuser[2:0];
	assign in_idx    = {s_tdata[1:0], s_tdata[3:2]};
	assign cord_start = acc_beat && (in_action inside {ACT_ROTX, ACT_ROTY, ACT_ROTZ});
	assign k         = t_q[1:0];
	assign is_point  = (action_q == ACT_POINT);

	// element of the operation matrix, row r, column c
	function automatic logic signed [31:0] op_elem(input logic [1:0] r, input logic [1:0] c);
		logic signed [31:0] v;
		logic [3:0]         idx;
		idx = {r, c};
		v = (r == c) ? ONE : 32'sd0;
		case (action_q)
			ACT_ROTX: begin
				if (idx == 4'd5 || idx == 4'd10) v = cs;
				if (idx == 4'd6) v = -sn;
				if (idx == 4'd9) v = sn;
			end
			ACT_ROTY: begin
				if (idx == 4'd0 || idx == 4'd10) v = cs;
				if (idx == 4'd2) v = sn;
				if (idx == 4'd8) v = -sn;
			end
			ACT_ROTZ: begin
				if (idx == 4'd0 || idx == 4'd5) v = cs;
				if (idx == 4'd1) v = -sn;
				if (idx == 4'd4) v = sn;
			end
			ACT_TRANS: begin
				if (idx == 4'd3)  v = vec_q[0];
				if (idx == 4'd7)  v = vec_q[1];
				if (idx == 4'd11) v = vec_q[2];
			end
			default: v = v;
		endcase
		return v;
	endfunction

	// operand selection for the shared multiplier
	always_comb begin
		if (is_point) begin
			op_a = bank_q[act_q][{i_q, k}];
			op_b = vec_q[k];
		end else if (order_q) begin
			op_a = bank_q[act_q][{i_q, k}];
			op_b = op_elem(k, j_q);
		end else begin
			op_a = op_elem(i_q, k);
			op_b = bank_q[act_q][{k, j_q}];
		end
		mctl.mul_en  = (state_q == ST_MAC) && (t_q < 3'd4);
		mctl.acc_clr = (state_q == ST_MAC) && (t_q == 3'd0);
		mctl.acc_en  = (state_q == ST_MAC) && (t_q != 3'd0) && (t_q < 3'd5);
	end

	htf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (s_tdata[51:36]),
		.done   (cord_done),
		.sn     (sn),
		.cs     (cs)
	);

	htf_mac u_mac (
		.clk    (clk),
		.ctrl   (mctl),
		.a      (op_a),
		.b      (op_b),
		.result (mac_res),
		.ovf    (mac_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			act_q    <= 1'b0;
			ov_q     <= 1'b0;
			m_tvalid <= 1'b0;
			t_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			for (int b = 0; b < 2; b++) begin
				for (int e = 0; e < 16; e++) begin
					bank_q[b][e] <= (e == 15) ? ONE : 32'sd0;
				end
			end
		end else begin
			// the handover below reloads the beat itself
			if (m_tvalid && m_tready && state_q != ST_PUT) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_beat) begin
						action_q <= in_action;
						order_q  <= s_tuser[3];
						vec_q[0] <= s_tdata[83:52];
						vec_q[1] <= s_tdata[115:84];
						vec_q[2] <= s_tdata[147:116];
						vec_q[3] <= s_tdata[179:148];
						t_q <= '0;
						i_q <= '0;
						j_q <= '0;
						case (in_action)
							ACT_IDENT: begin
								for (int e = 0; e < 16; e++) begin
									bank_q[act_q][e] <= (e % 5 == 0) ? ONE : 32'sd0;
								end
							end
							ACT_LOAD:  bank_q[act_q][in_idx] <= s_tdata[35:4];
							ACT_ROTX, ACT_ROTY, ACT_ROTZ: state_q <= ST_CORD;
							ACT_TRANS, ACT_POINT: state_q <= ST_MAC;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CORD: begin
					if (cord_done) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (t_q == 3'd5) begin
						t_q <= '0;
						if (mac_ovf) begin
							ov_q <= 1'b1;
						end
						if (is_point) begin
							res_q[i_q] <= mac_res;
							i_q <= i_q + 1'b1;
							if (i_q == 2'd3) begin
								state_q <= ST_PUT;
							end
						end else begin
							bank_q[!act_q][{i_q, j_q}] <= mac_res;
							j_q <= j_q + 1'b1;
							if (j_q == 2'd3) begin
								i_q <= i_q + 1'b1;
							end
							if (i_q == 2'd3 && j_q == 2'd3) begin
								act_q   <= !act_q;
								state_q <= ST_IDLE;
							end
						end
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				ST_PUT: begin
					// hand over once the output register is free
					if (!m_tvalid || m_tready) begin
						m_tdata  <= {res_q[3], res_q[2], res_q[1], res_q[0]};
						m_tuser  <= ov_q;
						m_tvalid <= 1'b1;
						ov_q     <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// element step counter never passes the write step
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (t_q <= 3'd5))
		else $error("mac step counter out of range");

	// handover of a point result loads the output beat and clears the flag
	a_put: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && (!m_tvalid || m_tready)) |=> (m_tvalid && !ov_q))
		else $error("point result not handed over");

	// the active bank only flips at the end of a composition
	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(act_q) |-> ($past(state_q) == ST_MAC && !$past(is_point)))
		else $error("bank flipped outside a composition");

	// identity and load beats finish in their accept cycle
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_beat && (in_action == ACT_IDENT || in_action == ACT_LOAD)) |=>
		(state_q == ST_IDLE))
		else $error("short action left the idle state");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench of homogeneous_transform_engine_unit
// depends on htf_pkg and the engine rtl; a local fixed-point matrix model predicts each point result
`default_nettype none
module tb_top;
	import htf_pkg::*;

	localparam logic [2:0] ACT_NONE = 3'd7;
	localparam int SETTLE_CYCLES = 300;

	// cordic arc tangents at 30 fraction bits, one per step
	localparam longint ARC_TAN [16] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768
	};

	typedef struct {
		logic [2:0] action;
		bit         order;
		bit [1:0]   row;
		bit [1:0]   col;
		int         value;
		shortint    angle;
		int         x, y, z, w;
	} beat_t;

	typedef struct {
		int coord [4];
		bit sat;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic m_tuser;

	// model state
	int     matrix [16];
	bit     sat_seen;
	point_t pending_points [$];
	int     mismatches;
	int     burst_left;

	homogeneous_transform_engine_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// fixed-point dot product: exact sum, round half up, saturate to 32 bits
	function automatic int dot4(input int a [4], input int b [4], inout bit ovf);
		longint p, hi, lo;
		hi = 0;
		lo = 0;
		for (int k = 0; k < 4; k++) begin
			p = longint'(a[k]) * longint'(b[k]);
			hi += p >>> FRAC_BITS;
			lo += p & ((64'sd1 <<< FRAC_BITS) - 1);
		end
		lo += 64'sd1 <<< (FRAC_BITS - 1);
		hi += lo >>> FRAC_BITS;
		if (hi > 64'sd2147483647) begin
			ovf = 1'b1;
			return 32'h7fffffff;
		end
		if (hi < -64'sd2147483648) begin
			ovf = 1'b1;
			return 32'h80000000;
		end
		return int'(hi);
	endfunction

	// order 0: op * matrix, order 1: matrix * op
	function automatic void compose_matrix(input int op [16], input bit order);
		int lhs [16], rhs [16], res [16], r [4], c [4];
		bit ovf;
		ovf = 1'b0;
		if (order) begin
			lhs = matrix;
			rhs = op;
		end else begin
			lhs = op;
			rhs = matrix;
		end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 4; k++) begin
					r[k] = lhs[i*4+k];
					c[k] = rhs[k*4+j];
				end
				res[i*4+j] = dot4(r, c, ovf);
			end
		matrix = res;
		if (ovf)
			sat_seen = 1'b1;
	endfunction

	function automatic int to_q(input longint v);
		longint r, one;
		one = 64'sd1 <<< FRAC_BITS;
		r = (v + (64'sd1 <<< (CF - FRAC_BITS - 1))) >>> (CF - FRAC_BITS);
		if (r > one) r = one;
		if (r < -one) r = -one;
		return int'(r);
	endfunction

	function automatic void sine_cosine(input shortint angle, output int sn, output int cs);
		longint a, cx, cy, cz, dx, dy;
		bit flip;
		flip = 1'b0;
		a = longint'(angle) % 5760;
		if (a < 0) a += 5760;
		if (a > 2880) a -= 5760;
		// fold into a quarter turn either side, negating both outputs
		if (a > 1440) begin
			a -= 2880;
			flip = 1'b1;
		end else if (a < -1440) begin
			a += 2880;
			flip = 1'b1;
		end
		cz = (a * 64'sd1199381129 + 512) >>> 10;
		cx = 652032874;
		cy = 0;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cz >= 0) begin
				cx -= dx; cy += dy; cz -= ARC_TAN[i];
			end else begin
				cx += dx; cy -= dy; cz += ARC_TAN[i];
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		sn = to_q(cy);
		cs = to_q(cx);
	endfunction

	function automatic void identity(output int m [16]);
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? int'(ONE) : 0;
	endfunction

	// apply one accepted beat to the model, queue a point result where one is due
	function automatic void apply_beat(input beat_t b);
		int op [16], row_v [4], pt [4];
		int sn, cs;
		point_t res;
		bit ovf;
		identity(op);
		case (b.action)
			ACT_IDENT: identity(matrix);
			ACT_LOAD:  matrix[b.row*4 + b.col] = b.value;
			ACT_ROTX, ACT_ROTY, ACT_ROTZ: begin
				sine_cosine(b.angle, sn, cs);
				if (b.action == ACT_ROTX) begin
					op[5] = cs; op[6] = -sn; op[9] = sn; op[10] = cs;
				end else if (b.action == ACT_ROTY) begin
					op[0] = cs; op[2] = sn; op[8] = -sn; op[10] = cs;
				end else begin
					op[0] = cs; op[1] = -sn; op[4] = sn; op[5] = cs;
				end
				compose_matrix(op, b.order);
			end
			ACT_TRANS: begin
				op[3] = b.x; op[7] = b.y; op[11] = b.z;
				compose_matrix(op, b.order);
			end
			ACT_POINT: begin
				ovf = sat_seen;
				pt = '{b.x, b.y, b.z, b.w};
				for (int i = 0; i < 4; i++) begin
					for (int k = 0; k < 4; k++)
						row_v[k] = matrix[i*4+k];
					res.coord[i] = dot4(row_v, pt, ovf);
				end
				res.sat = ovf;
				sat_seen = 1'b0;
				pending_points.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// send one beat: bursts of random length, mostly with idle gaps in between
	task automatic send_beat(input beat_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, b.w, b.z, b.y, b.x, b.angle, b.value, b.col, b.row};
		s_tuser  <= {b.order, b.action};
		do @(posedge clk); while (!s_tready);
		apply_beat(b);
		burst_left--;
	endtask

	function automatic beat_t noise_beat(input logic [2:0] action);
		beat_t b;
		b.action = action;
		b.order  = 1'($urandom_range(0, 1));
		b.row    = 2'($urandom_range(0, 3));
		b.col    = 2'($urandom_range(0, 3));
		b.value  = $urandom;
		b.angle  = shortint'($urandom);
		b.x = $urandom; b.y = $urandom; b.z = $urandom; b.w = $urandom;
		return b;
	endfunction

	// q16.16 value within +-8, or full range now and then
	function automatic int rand_q(input bit full);
		if (full)
			return $urandom;
		return int'($urandom_range(0, 32'h000fffff)) - 32'h00080000;
	endfunction

	task automatic test_reset_state();
		beat_t b;
		b = noise_beat(ACT_POINT);
		b.x = 32'h7fffffff; b.y = 32'h80000000; b.z = 12345; b.w = 32'h80000000;
		send_beat(b);
		b.w = 32'h7fffffff;
		send_beat(b);
	endtask

	task automatic test_load_extremes();
		beat_t b;
		b = noise_beat(ACT_IDENT);
		send_beat(b);
		b = noise_beat(ACT_LOAD);
		b.row = 2'd0; b.col = 2'd0; b.value = 32'h7fffffff;
		send_beat(b);
		b.row = 2'd3; b.col = 2'd3; b.value = 32'h80000000;
		send_beat(b);
		b.row = 2'd1; b.col = 2'd2; b.value = -1;
		send_beat(b);
		// sums of extreme products saturate both ways
		b = noise_beat(ACT_POINT);
		b.x = 32'h7fffffff; b.y = 5; b.z = -7; b.w = 32'h7fffffff;
		send_beat(b);
		// flag was cleared by the previous result
		b.x = 0; b.y = 0; b.z = 0; b.w = 0;
		send_beat(b);
	endtask

	task automatic test_rotations();
		shortint angles [8] = '{0, 1440, -1440, 2880, -2880, 5760, 32767, -32768};
		beat_t b;
		send_beat(noise_beat(ACT_IDENT));
		foreach (angles[i]) begin
			b = noise_beat(ACT_ROTX + 3'(i % 3));
			b.angle = angles[i];
			send_beat(b);
		end
		b = noise_beat(ACT_POINT);
		b.x = 1 <<< 16; b.y = 2 <<< 16; b.z = -(3 <<< 16); b.w = 1 <<< 16;
		send_beat(b);
	endtask

	task automatic test_translation();
		beat_t b;
		send_beat(noise_beat(ACT_IDENT));
		b = noise_beat(ACT_TRANS);
		b.order = 1'b0; b.x = 32'h7fffffff; b.y = 32'h80000000; b.z = 3 <<< 16;
		send_beat(b);
		b.order = 1'b1;
		send_beat(b);
		// unused action leaves the matrix alone
		send_beat(noise_beat(ACT_NONE));
		b = noise_beat(ACT_POINT);
		b.x = 1 <<< 16; b.y = 1 <<< 16; b.z = 1 <<< 16; b.w = 1 <<< 16;
		send_beat(b);
	endtask

	task automatic test_random(input int count);
		beat_t b;
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				b = noise_beat(ACT_IDENT);
			else if (pick < 16) begin
				b = noise_beat(ACT_LOAD);
				if ($urandom_range(0, 1)) b.value = rand_q(1'b0);
			end else if (pick < 48)
				b = noise_beat(3'($urandom_range(ACT_ROTX, ACT_ROTZ)));
			else if (pick < 66) begin
				b = noise_beat(ACT_TRANS);
				if ($urandom_range(0, 9) != 0) begin
					b.x = rand_q(1'b0); b.y = rand_q(1'b0); b.z = rand_q(1'b0);
				end
			end else if (pick < 97) begin
				b = noise_beat(ACT_POINT);
				if ($urandom_range(0, 7) != 0) begin
					b.x = rand_q(1'b0); b.y = rand_q(1'b0); b.z = rand_q(1'b0);
					b.w = $urandom_range(0, 3) ? int'(ONE) : rand_q(1'b0);
				end
			end else
				b = noise_beat(ACT_NONE);
			send_beat(b);
		end
	endtask

	// receiver stalls on its own pattern: phases of always-ready and random stalls
	initial begin
		int phase_left, mode;
		phase_left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 400);
				mode = $urandom_range(0, 2);
			end
			phase_left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// compare each result beat with the oldest expected point
	always @(posedge clk) begin
		point_t exp_pt;
		logic [M_DATA_W-1:0] exp_data;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: data %h sat %b", m_tdata, m_tuser);
			end else begin
				exp_pt = pending_points.pop_front();
				exp_data = {exp_pt.coord[3], exp_pt.coord[2], exp_pt.coord[1], exp_pt.coord[0]};
				for (int i = 0; i < 4; i++)
					if (m_tdata[i*32 +: 32] !== exp_data[i*32 +: 32]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("coord %0d: expected %h got %h", i,
								exp_data[i*32 +: 32], m_tdata[i*32 +: 32]);
					end
				if (m_tuser !== exp_pt.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("saturated: expected %b got %b", exp_pt.sat, m_tuser);
				end
			end
		end
	end

	initial begin
		#25000000;
		$display("FAIL homogeneous_transform_engine_unit");
		$finish;
	end

	initial begin
		mismatches = 0;
		burst_left = 0;
		matrix = '{default: 0};
		matrix[15] = ONE;
		sat_seen = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_load_extremes();
		test_rotations();
		test_translation();
		test_random(1200);
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_points.size() == 0)
			$display("PASS homogeneous_transform_engine_unit");
		else
			$display("FAIL homogeneous_transform_engine_unit");
		$finish;
	end

endmodule
`default_nettype wire
